// File: rtl/core/tmk_pkg.sv
// Shared types and constants for the top-M magnitude keep unit.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package tmk_pkg;

    // Frame capacity and coefficient format
    localparam int MAX_POINTS = 64;
    localparam int COEF_WIDTH = 16;

    // Derived widths
    localparam int IDX_W  = $clog2(MAX_POINTS);        // coefficient index / rank
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);    // fill count, 0..MAX_POINTS
    localparam int KEEP_W = 7;                         // keep_count register
    localparam int MAG_W  = 2 * COEF_WIDTH;            // squared magnitude
    localparam int NGRP   = (MAX_POINTS + 7) / 8;      // popcount groups of eight
    localparam int GCNT_W = 4;                         // 0..8 per group

    // Input transfer payload
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_real;
        logic signed [COEF_WIDTH-1:0] coef_imag;
        logic                         frame_last;
    } t_in_item;

    // Result transfer payload
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] out_real;
        logic signed [COEF_WIDTH-1:0] out_imag;
        logic [IDX_W-1:0]             bin_index;
        logic                         out_last;
        logic                         overflow;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture input item
        logic drop;     // frame full: flag the dropped item
        logic mag;      // register the two squares
        logic cmp;      // compare against stored cells, store entry
        logic part;     // partial popcounts of the compare vector
        logic sum;      // final rank of the new entry, bump the count
        logic rd;       // read one stored entry for output
        logic clear;    // end of frame: reset count and drop flag
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;     // MAX_POINTS entries stored
        logic last;     // captured item carries the frame marker
        logic rd_final; // current read address is the last entry
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/core/tmk_ctrl.sv
// Controller state machine for the top-M magnitude keep unit.
// Depends on tmk_pkg; drives tmk_datapath through t_dp_cmd.
`default_nettype none

module tmk_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_last,
    input  wire tmk_pkg::t_dp_stat i_stat,
    output tmk_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy
);
    import tmk_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAG  = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_PART = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.drop = 1'b1;
                        if (i_last) begin
                            n_state = ST_EMIT;
                        end
                    end else begin
                        n_state = ST_MAG;
                    end
                end
            end
            ST_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_PART;
            end
            ST_PART: begin
                o_cmd.part = 1'b1;
                n_state    = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = i_stat.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                o_cmd.rd = 1'b1;
                if (i_stat.rd_final) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/tmk_datapath.sv
// Datapath: magnitude squares, per-entry compare and rank cells, coefficient
// memory and the output read pipeline. Depends on tmk_pkg; driven by tmk_ctrl.
`default_nettype none

module tmk_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tmk_pkg::t_in_item  i_item,
    input  wire logic               i_cfg_we,
    input  wire logic [tmk_pkg::KEEP_W-1:0] i_cfg_wdata,
    input  wire tmk_pkg::t_dp_cmd   i_cmd,
    output tmk_pkg::t_dp_stat       o_stat,
    output logic                    o_strobe,
    output tmk_pkg::t_out_item      o_result
);
    import tmk_pkg::*;

    // Configuration and frame state
    logic [KEEP_W-1:0] r_keep;
    logic [CNT_W-1:0]  r_count;
    logic              r_dropped;
    logic [IDX_W-1:0]  r_rd_addr;

    // Item pipeline
    t_in_item          r_in;
    logic [MAG_W-1:0]  r_sq_re;
    logic [MAG_W-1:0]  r_sq_im;
    logic [NGRP*8-1:0] r_ge;
    logic [GCNT_W-1:0] r_part [NGRP];

    // Per-entry cells and coefficient memory
    logic [MAG_W-1:0]      r_magsq [MAX_POINTS];
    logic [IDX_W-1:0]      r_rank  [MAX_POINTS];
    logic [COEF_WIDTH-1:0] r_mem_re [MAX_POINTS];
    logic [COEF_WIDTH-1:0] r_mem_im [MAX_POINTS];

    // Read pipeline
    logic                  r_rd_vld;
    logic [COEF_WIDTH-1:0] r_rd_re;
    logic [COEF_WIDTH-1:0] r_rd_im;
    logic [IDX_W-1:0]      r_rd_rank;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_rd_last;
    logic                  r_rd_ovf;

    logic [MAG_W-1:0]  mag;
    logic [IDX_W-1:0]  wr_idx;
    logic [CNT_W-1:0]  rank_sum;
    logic              kept;
    logic [NGRP*8-1:0] ge_vec;
    logic signed [MAG_W-1:0] re_x;
    logic signed [MAG_W-1:0] im_x;

    assign mag    = r_sq_re + r_sq_im;
    assign wr_idx = r_count[IDX_W-1:0];

    // Sign-extended parts so the squares keep their full width
    assign re_x = {{(MAG_W-COEF_WIDTH){r_in.coef_real[COEF_WIDTH-1]}}, r_in.coef_real};
    assign im_x = {{(MAG_W-COEF_WIDTH){r_in.coef_imag[COEF_WIDTH-1]}}, r_in.coef_imag};

    assign o_stat.full     = (r_count == CNT_W'(MAX_POINTS));
    assign o_stat.last     = r_in.frame_last;
    assign o_stat.rd_final = ((CNT_W'(r_rd_addr) + CNT_W'(1)) == r_count);

    // Keep count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= KEEP_W'(MAX_POINTS);
        end else if (i_cfg_we) begin
            r_keep <= i_cfg_wdata;
        end
    end

    // Frame count, drop flag, read address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_rd_addr <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
                r_rd_addr <= '0;
            end else begin
                if (i_cmd.sum) begin
                    r_count <= r_count + CNT_W'(1);
                end
                if (i_cmd.drop) begin
                    r_dropped <= 1'b1;
                end
                if (i_cmd.rd) begin
                    r_rd_addr <= r_rd_addr + IDX_W'(1);
                end
            end
        end
    end

    // Input capture and squares
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        if (i_cmd.mag) begin
            r_sq_re <= $unsigned(re_x * re_x);
            r_sq_im <= $unsigned(im_x * im_x);
        end
    end

    // Compare vector: stored entries at least as large as the new one
    always_comb begin
        ge_vec = '0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            ge_vec[i] = (CNT_W'(i) < r_count) && (r_magsq[i] >= mag);
        end
    end

    // Compare cells: smaller stored entries move down one rank
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_ge <= ge_vec;
            for (int i = 0; i < MAX_POINTS; i++) begin
                if ((CNT_W'(i) < r_count) && (r_magsq[i] < mag)) begin
                    r_rank[i] <= r_rank[i] + IDX_W'(1);
                end
            end
            r_magsq[wr_idx] <= mag;
        end
        if (i_cmd.sum) begin
            r_rank[wr_idx] <= rank_sum[IDX_W-1:0];
        end
    end

    // Popcount, first level: groups of eight
    always_ff @(posedge i_clk) begin
        if (i_cmd.part) begin
            for (int g = 0; g < NGRP; g++) begin
                r_part[g] <= GCNT_W'(r_ge[g*8 +: 8] != 8'd0 ? $countones(r_ge[g*8 +: 8]) : 0);
            end
        end
    end

    // Popcount, second level
    always_comb begin
        rank_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            rank_sum = rank_sum + CNT_W'(r_part[g]);
        end
    end

    // Coefficient memory write
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_mem_re[wr_idx] <= r_in.coef_real;
            r_mem_im[wr_idx] <= r_in.coef_imag;
        end
    end

    // Coefficient memory read, with rank and frame tags
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_re   <= r_mem_re[r_rd_addr];
            r_rd_im   <= r_mem_im[r_rd_addr];
            r_rd_rank <= r_rank[r_rd_addr];
            r_rd_idx  <= r_rd_addr;
            r_rd_last <= o_stat.rd_final;
            r_rd_ovf  <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            o_strobe <= r_rd_vld;
        end
    end

    // Output register: zero the entries ranked outside the keep count
    assign kept = (KEEP_W'(r_rd_rank) < r_keep);

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            o_result.out_real  <= kept ? r_rd_re : '0;
            o_result.out_imag  <= kept ? r_rd_im : '0;
            o_result.bin_index <= r_rd_idx;
            o_result.out_last  <= r_rd_last;
            o_result.overflow  <= r_rd_ovf;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/top_m_magnitude_keep_unit.sv
// Top level of the top-M magnitude keep unit.
// Depends on tmk_pkg, tmk_ctrl and tmk_datapath.
`default_nettype none

// A frame of complex coefficients is loaded one transfer at a time; each stored
// coefficient passes through acceptance, square, compare, partial count and
// final count of its rank against all stored entries, in that order, before
// the next transfer is accepted. A coefficient arriving once 64 are stored is
// dropped and the frame is flagged. After the transfer marked frame_last, the
// frame is replayed in index order, one result per cycle; memory reads start in
// the cycle after the last item's processing ends; each read passes the read
// and output registers, the latter with its strobe; busy lasts to the last read.
// The receiver cannot stall: each result is valid only in its strobe cycle.
// Results outside the keep_count largest magnitudes are zeroed (ties favor
// lower index). keep_count may only be written while no frame is in flight.
module top_m_magnitude_keep_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire tmk_pkg::t_in_item            i_item,
    input  wire logic                         i_cfg_we,
    input  wire logic [tmk_pkg::KEEP_W-1:0]   i_cfg_wdata,
    output logic                              o_strobe,
    output tmk_pkg::t_out_item                o_result
);
    import tmk_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    tmk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_last  (i_item.frame_last),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // Storage, ranking and output
    tmk_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire
